@@ hdl/midi_parser_with_channel_activity_assert.svh @@
// Assertion macros shared by the MIDI parser RTL.
`ifndef MIDI_PARSER_WITH_CHANNEL_ACTIVITY_ASSERT_SVH
`define MIDI_PARSER_WITH_CHANNEL_ACTIVITY_ASSERT_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define MPCA_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Check a property on every clock edge, reset included.
`define MPCA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define MPCA_ASSERT(label, clk, rstn, prop)
`define MPCA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ hdl/mpca_pkg.sv @@
// Shared types and constants of the MIDI parser with channel activity.
package mpca_pkg;

  // Status bytes and thresholds
  localparam logic [7:0] StatusSysex  = 8'hF0;
  localparam logic [7:0] SongPosition = 8'hF2;
  localparam logic [7:0] RealtimeMin  = 8'hF8;

  // Message types (status bits 6..4)
  localparam logic [2:0] TypCtrlChange = 3'd3;
  localparam logic [2:0] TypProgram    = 3'd4;
  localparam logic [2:0] TypPressure   = 3'd5;
  localparam logic [2:0] TypPitchWheel = 3'd6;
  localparam logic [2:0] TypSystem     = 3'd7;

  // System message subtypes
  localparam logic [3:0] SubSysex      = 4'h0;
  localparam logic [3:0] SubTimeCode   = 4'h1;
  localparam logic [3:0] SubSongPos    = 4'h2;
  localparam logic [3:0] SubSongSelect = 4'h3;

  // Saturation limit of six-bit counts
  localparam logic [5:0] CountMax = 6'd63;

  // Configuration register reset values
  localparam logic [3:0] StepReset      = 4'd5;
  localparam logic [5:0] CeilingReset   = 6'd40;
  localparam logic [5:0] ThresholdReset = 6'd58;

  typedef enum logic [1:0] {
    CfgBumpStep       = 2'd0,
    CfgBumpCeiling    = 2'd1,
    CfgFlushThreshold = 2'd2
  } cfg_reg_e;

  // Input item kind and result kind share one coding
  typedef enum logic {
    KindByte = 1'b0,
    KindTick = 1'b1
  } item_kind_e;

  // Command to the activity counter bank
  typedef struct packed {
    logic bump;
    logic tick;
  } cnt_cmd_t;

endpackage

@@ hdl/mpca_counters.sv @@
// Per-channel activity counters with saturating bump, tick decay and LED status.
module mpca_counters #(
  parameter int Channels = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mpca_pkg::cnt_cmd_t            cmd_i,
  input  logic [$clog2(Channels)-1:0]   ch_i,
  input  logic [3:0]                    step_i,
  input  logic [5:0]                    ceiling_i,
  output logic [Channels/2-1:0]         low_leds_o,
  output logic                          high_led_o
);

  localparam int ChW  = $clog2(Channels);
  localparam int LedW = Channels / 2;

  logic [5:0] cnt_q [Channels];
  logic [5:0] cnt_d [Channels];
  logic [6:0] sum   [Channels];

  // Bump the addressed counter below the ceiling, decay all on a tick
  always_comb begin
    for (int i = 0; i < Channels; i++) begin
      sum[i]   = {1'b0, cnt_q[i]} + {3'b000, step_i};
      cnt_d[i] = cnt_q[i];
      if (cmd_i.tick) begin
        if (cnt_q[i] != 6'd0) cnt_d[i] = cnt_q[i] - 6'd1;
      end else if (cmd_i.bump && (ch_i == ChW'(i)) && (cnt_q[i] < ceiling_i)) begin
        cnt_d[i] = sum[i][6] ? mpca_pkg::CountMax : sum[i][5:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) cnt_q[i] <= 6'd0;
    end else begin
      for (int i = 0; i < Channels; i++) cnt_q[i] <= cnt_d[i];
    end
  end

  // Fold upper channels onto the low LEDs
  always_comb begin
    high_led_o = 1'b0;
    for (int j = 0; j < LedW; j++) begin
      low_leds_o[j] = (cnt_q[j] != 6'd0) || (cnt_q[j + LedW] != 6'd0);
      high_led_o    = high_led_o || (cnt_q[j + LedW] != 6'd0);
    end
  end

endmodule

@@ hdl/mpca_fifo.sv @@
// Small result queue: up to two writes and one read per cycle.
`include "midi_parser_with_channel_activity_assert.svh"

module mpca_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_n_i,
  input  logic [Width-1:0]           din0_i,
  input  logic [Width-1:0]           din1_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output logic [Width-1:0]           dout_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, wr_nx, rd_q, rd_d;
  logic [CntW-1:0]  count_q, count_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Advance pointers and occupancy
  always_comb begin
    wr_nx   = next_ptr(wr_q);
    wr_d    = wr_q;
    if (push_n_i == 2'd1) wr_d = wr_nx;
    if (push_n_i == 2'd2) wr_d = next_ptr(wr_nx);
    rd_d    = pop_i ? next_ptr(rd_q) : rd_q;
    count_d = count_q + CntW'(push_n_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wr_q] <= din0_i;
    if (push_n_i == 2'd2) mem_q[wr_nx] <= din1_i;
  end

  assign valid_o = (count_q != '0);
  assign dout_o  = mem_q[rd_q];
  assign count_o = count_q;

  `MPCA_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Depth))
  `MPCA_ASSERT(a_no_overflow, clk_i, rst_ni,
               (push_n_i != 2'd0) |->
               ({1'b0, count_q} + (CntW + 1)'(push_n_i) <=
                (CntW + 1)'(Depth) + (CntW + 1)'(pop_i)))
  `MPCA_ASSERT(a_no_underflow, clk_i, rst_ni, pop_i |-> (count_q != '0))

endmodule

@@ hdl/midi_parser_with_channel_activity.sv @@
// Top level: MIDI running-status parser with per-channel activity counters.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries kind_i and rx_byte_i: a
//   MIDI byte (kind 0) or a timer tick (kind 1). Each item yields zero, one
//   or two results on the output channel (out_valid_o/out_ready_i): recorded
//   packet bytes, or one LED update per tick. last_of_run_o marks the final
//   result of an item. The configuration channel (cfg_valid_i, always ready)
//   writes bump_step, bump_ceiling and flush_threshold by index.
// Timing:
//   An item lands in an input register, is parsed from there and its
//   results enter a four-entry result queue, which offers them on the
//   output channel. An item is parsed only while the queue holds two
//   entries or fewer. With the receiver always ready, items with at most
//   one result go at one per cycle; a run of two-result items is held back
//   to the rate at which results leave.
// Reset clears all counters, parser state and the queue, and loads the
// register defaults. When the receiver stalls, results wait in the queue and
// input is taken until the queue and the input register fill.
`include "midi_parser_with_channel_activity_assert.svh"

module midi_parser_with_channel_activity #(
  parameter int CHANNELS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [5:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  result_kind_o,
  output logic [7:0]            out_byte_o,
  output logic                  packet_end_o,
  output logic [CHANNELS/2-1:0] low_leds_o,
  output logic                  high_led_o,
  output logic                  last_of_run_o
);

  localparam int ChW      = $clog2(CHANNELS);
  localparam int LedW     = CHANNELS / 2;
  localparam int ResW     = 12 + LedW;
  localparam int ResDepth = 4;
  localparam int ResCntW  = $clog2(ResDepth + 1);

  // Configuration registers
  logic [3:0] step_q;
  logic [5:0] ceiling_q, thresh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= mpca_pkg::StepReset;
      ceiling_q <= mpca_pkg::CeilingReset;
      thresh_q  <= mpca_pkg::ThresholdReset;
    end else if (cfg_valid_i) begin
      unique case (mpca_pkg::cfg_reg_e'(cfg_index_i))
        mpca_pkg::CfgBumpStep:       step_q    <= cfg_data_i[3:0];
        mpca_pkg::CfgBumpCeiling:    ceiling_q <= cfg_data_i;
        mpca_pkg::CfgFlushThreshold: thresh_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  logic                     inq_valid_q;
  mpca_pkg::item_kind_e     inq_kind_q;
  logic [7:0]               inq_byte_q;
  logic                     fire;
  logic [ResCntW-1:0]       res_count;

  assign fire       = inq_valid_q && (res_count <= ResCntW'(ResDepth - 2));
  assign in_ready_o = !inq_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      inq_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_kind_q <= mpca_pkg::item_kind_e'(kind_i);
      inq_byte_q <= rx_byte_i;
    end
  end

  // Parser state
  logic [7:0] cur_q, cur_d, last_q, last_d, first_q, first_d;
  logic [1:0] left_q, left_d;
  logic       skip_q, skip_d;
  logic [5:0] pbc_q, pbc_d;

  // Data bytes that follow a status byte
  function automatic logic [1:0] msg_len(input logic [7:0] s);
    logic [1:0] len;
    len = 2'd2;
    case (s[6:4]) inside
      mpca_pkg::TypProgram, mpca_pkg::TypPressure: len = 2'd1;
      mpca_pkg::TypSystem: begin
        case (s[3:0]) inside
          mpca_pkg::SubSysex, mpca_pkg::SubTimeCode,
          mpca_pkg::SubSongSelect: len = 2'd1;
          mpca_pkg::SubSongPos:    len = 2'd2;
          default:                 len = 2'd0;
        endcase
      end
      default: len = 2'd2;
    endcase
    return len;
  endfunction

  // Count one recorded byte; returns {packet_end, new count}
  function automatic logic [6:0] rec(input logic [5:0] cnt, input logic [5:0] thr,
                                     input logic closes);
    logic [5:0] inc;
    logic       pe;
    inc = (cnt < mpca_pkg::CountMax) ? cnt + 6'd1 : cnt;
    pe  = closes && ((inc > thr) || (inc == mpca_pkg::CountMax));
    return {pe, pe ? 6'd0 : inc};
  endfunction

  mpca_pkg::cnt_cmd_t cmd;
  logic [ChW-1:0]     bump_ch;
  logic               start, do_data, combined, pe;
  logic [7:0]         st_byte, c, v;
  logic [1:0]         n_res;
  logic [7:0]         r_byte0, r_byte1;
  logic               r_pe0, r_pe1;

  // Parse one item
  always_comb begin
    c        = inq_byte_q;
    cur_d    = cur_q;
    last_d   = last_q;
    left_d   = left_q;
    first_d  = first_q;
    skip_d   = skip_q;
    pbc_d    = pbc_q;
    cmd      = '0;
    bump_ch  = c[ChW-1:0];
    start    = 1'b0;
    do_data  = 1'b0;
    st_byte  = c;
    n_res    = 2'd0;
    r_byte0  = 8'h00;
    r_byte1  = 8'h00;
    r_pe0    = 1'b0;
    r_pe1    = 1'b0;
    combined = 1'b0;
    pe       = 1'b0;
    v        = 8'h00;

    // Dispatch on parser state
    if (inq_kind_q == mpca_pkg::KindTick) begin
      cmd.tick = 1'b1;
    end else if (skip_q) begin
      if (c[7]) begin
        skip_d = 1'b0;
        start  = 1'b1;
      end
    end else if (c >= mpca_pkg::RealtimeMin) begin
      start = 1'b0;
    end else if (left_q != 2'd0) begin
      do_data = 1'b1;
    end else if (c[7]) begin
      start = 1'b1;
    end else if (last_q[7]) begin
      start   = 1'b1;
      st_byte = last_q;
      do_data = 1'b1;
    end else begin
      cmd.bump = 1'b1;
    end

    // Start a message
    if (start) begin
      cmd.bump     = 1'b1;
      bump_ch      = st_byte[ChW-1:0];
      cur_d        = st_byte;
      last_d       = (st_byte[6:4] == mpca_pkg::TypSystem) ? 8'h00 : st_byte;
      left_d       = msg_len(st_byte);
      {pe, pbc_d}  = rec(pbc_d, thresh_q, left_d == 2'd0);
      r_byte0      = st_byte;
      r_pe0        = pe;
      n_res        = 2'd1;
    end

    // Take a data byte
    if (do_data) begin
      combined = (cur_d[6:4] == mpca_pkg::TypPitchWheel) || (cur_d == mpca_pkg::SongPosition);
      if (combined && (left_d == 2'd2)) begin
        first_d = c;
        left_d  = 2'd1;
      end else begin
        if (combined) v = {first_d[7] | c[0], first_d[6:0]};
        else if ((cur_d[6:4] == mpca_pkg::TypCtrlChange) && (left_d == 2'd2))
          v = {1'b0, c[6:0]};
        else v = c;
        left_d      = left_d - 2'd1;
        {pe, pbc_d} = rec(pbc_d, thresh_q, left_d == 2'd0);
        if (n_res == 2'd0) begin
          r_byte0 = v;
          r_pe0   = pe;
        end else begin
          r_byte1 = v;
          r_pe1   = pe;
        end
        n_res = n_res + 2'd1;
        if ((left_d == 2'd0) && (cur_d == mpca_pkg::StatusSysex)) skip_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= 8'h00;
      last_q  <= 8'h00;
      first_q <= 8'h00;
      left_q  <= 2'd0;
      skip_q  <= 1'b0;
      pbc_q   <= 6'd0;
    end else if (fire) begin
      cur_q   <= cur_d;
      last_q  <= last_d;
      first_q <= first_d;
      left_q  <= left_d;
      skip_q  <= skip_d;
      pbc_q   <= pbc_d;
    end
  end

  // Activity counters
  mpca_pkg::cnt_cmd_t cnt_cmd;
  logic [LedW-1:0]    leds;
  logic               high;

  assign cnt_cmd = fire ? cmd : '0;

  mpca_counters #(
    .Channels (CHANNELS)
  ) u_counters (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cnt_cmd),
    .ch_i       (bump_ch),
    .step_i     (step_q),
    .ceiling_i  (ceiling_q),
    .low_leds_o (leds),
    .high_led_o (high)
  );

  // Build result entries
  logic [1:0]      push_n;
  logic [ResW-1:0] res0, res1, res_out;
  logic            is_tick;

  assign is_tick = (inq_kind_q == mpca_pkg::KindTick);
  assign push_n  = !fire ? 2'd0 : (is_tick ? 2'd1 : n_res);
  assign res0    = is_tick
                 ? {mpca_pkg::KindTick, 8'h00, 1'b0, leds, high, 1'b1}
                 : {mpca_pkg::KindByte, r_byte0, r_pe0, {LedW{1'b0}}, 1'b0, n_res == 2'd1};
  assign res1    = {mpca_pkg::KindByte, r_byte1, r_pe1, {LedW{1'b0}}, 1'b0, 1'b1};

  mpca_fifo #(
    .Width (ResW),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .din0_i   (res0),
    .din1_i   (res1),
    .pop_i    (out_valid_o && out_ready_i),
    .valid_o  (out_valid_o),
    .dout_o   (res_out),
    .count_o  (res_count)
  );

  assign {result_kind_o, out_byte_o, packet_end_o, low_leds_o, high_led_o,
          last_of_run_o} = res_out;

  `MPCA_ASSERT(a_left_range, clk_i, rst_ni, left_q != 2'd3)
  `MPCA_ASSERT(a_skip_no_data, clk_i, rst_ni, skip_q |-> (left_q == 2'd0))
  `MPCA_ASSERT(a_stall_holds_item, clk_i, rst_ni, !in_ready_o |-> inq_valid_q)
  `MPCA_ASSERT(a_tick_leaves_parser, clk_i, rst_ni,
               (fire && is_tick) |=> ($stable(left_q) && $stable(skip_q) && $stable(pbc_q)))

endmodule
